@@ rtl/core/jsd_pkg.sv @@
package jsd_pkg;

  // One accepted source item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       source_ended;
  } jsd_in_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] result_kind;
    logic [3:0] error_code;
    logic       last_of_run;
  } jsd_out_t;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE     = 4'd1;
  localparam logic [3:0] ERR_CONTROL      = 4'd2;
  localparam logic [3:0] ERR_BAD_LEAD     = 4'd3;
  localparam logic [3:0] ERR_BAD_CONT     = 4'd4;
  localparam logic [3:0] ERR_UTF8_CUT     = 4'd5;
  localparam logic [3:0] ERR_ESC_CUT      = 4'd6;
  localparam logic [3:0] ERR_BAD_ESC      = 4'd7;
  localparam logic [3:0] ERR_HEX_CUT      = 4'd8;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd9;
  localparam logic [3:0] ERR_LONE_HIGH    = 4'd10;
  localparam logic [3:0] ERR_BAD_LOW      = 4'd11;
  localparam logic [3:0] ERR_LONE_LOW     = 4'd12;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd13;

  // All results caused by one source item. cnt holds the result count minus one.
  // Runs of kind end or error always hold exactly one result.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [3:0][7:0] bytes;
    logic [1:0]      kind;
    logic [3:0]      err;
  } jsd_run_t;

  localparam int unsigned RUN_FIFO_DEPTH = 4;
  localparam int unsigned RUN_PTR_W      = $clog2(RUN_FIFO_DEPTH);
  localparam int unsigned RUN_CNT_W      = $clog2(RUN_FIFO_DEPTH + 1);

endpackage

@@ rtl/core/jsd_front.sv @@
module jsd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  jsd_pkg::jsd_in_t in_i,
  output logic             run_valid_o,
  output jsd_pkg::jsd_run_t run_o
);
  import jsd_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE,
    M_BODY,
    M_CONT,
    M_ESC,
    M_HEX,
    M_SUR_BS,
    M_SUR_U,
    M_LOWHEX
  } mode_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  mode_e       mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic [9:0]  hi_q, hi_d;
  logic [1:0]  left_q, left_d;
  logic [1:0]  range_q, range_d;

  logic        fail;
  logic [3:0]  fail_code;
  logic [7:0]  b;
  logic        ended;
  logic [4:0]  digit;
  logic [15:0] acc_next;
  logic [20:0] cp_sup;
  logic [7:0]  lo_lim, hi_lim;

  // Hex digit value, 16 when the byte is not a digit.
  function automatic logic [4:0] hex_of(logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    return v;
  endfunction

  function automatic jsd_run_t enc(logic [20:0] cp);
    jsd_run_t r;
    r = '0;
    r.kind = KIND_BYTE;
    r.err  = ERR_NONE;
    if (cp <= 21'h7F) begin
      r.cnt      = 2'd0;
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.cnt      = 2'd1;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.cnt      = 2'd2;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt      = 2'd3;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  function automatic jsd_run_t single(logic [7:0] v, logic [1:0] k, logic [3:0] e);
    jsd_run_t r;
    r = '0;
    r.bytes[0] = v;
    r.kind     = k;
    r.err      = e;
    return r;
  endfunction

  assign b        = in_i.in_byte;
  assign ended    = in_i.source_ended;
  assign digit    = hex_of(b);
  assign acc_next = {acc_q[11:0], digit[3:0]};
  assign cp_sup   = 21'h10000 + {1'b0, hi_q, acc_next[9:0]};

  always_comb begin
    lo_lim = 8'h80;
    hi_lim = 8'hBF;
    if (range_q == 2'd1) lo_lim = (left_q == 2'd3) ? 8'h90 : 8'hA0;
    else if (range_q == 2'd2) hi_lim = (left_q == 2'd3) ? 8'h8F : 8'h9F;
  end

  always_comb begin
    mode_d      = mode_q;
    acc_d       = acc_q;
    dcnt_d      = dcnt_q;
    hi_d        = hi_q;
    left_d      = left_q;
    range_d     = range_q;
    fail        = 1'b0;
    fail_code   = ERR_NONE;
    run_valid_o = 1'b0;
    run_o       = single(8'h00, KIND_BYTE, ERR_NONE);

    unique case (mode_q)
      M_BODY: begin
        if (ended) begin
          fail = 1'b1; fail_code = ERR_UNTERMINATED;
        end else if (b == CH_QUOTE) begin
          mode_d      = M_IDLE;
          run_valid_o = 1'b1;
          run_o       = single(8'h00, KIND_END, ERR_NONE);
        end else if (b < 8'h20) begin
          fail = 1'b1; fail_code = ERR_CONTROL;
        end else if (b >= 8'h80) begin
          run_valid_o = 1'b1;
          run_o       = single(b, KIND_BYTE, ERR_NONE);
          mode_d      = M_CONT;
          unique case (b) inside
            [8'hC2:8'hDF]:               begin left_d = 2'd1; range_d = 2'd0; end
            8'hE0:                       begin left_d = 2'd2; range_d = 2'd1; end
            [8'hE1:8'hEC], 8'hEE, 8'hEF: begin left_d = 2'd2; range_d = 2'd0; end
            8'hED:                       begin left_d = 2'd2; range_d = 2'd2; end
            8'hF0:                       begin left_d = 2'd3; range_d = 2'd1; end
            [8'hF1:8'hF3]:               begin left_d = 2'd3; range_d = 2'd0; end
            8'hF4:                       begin left_d = 2'd3; range_d = 2'd2; end
            default: begin
              run_valid_o = 1'b0;
              fail = 1'b1; fail_code = ERR_BAD_LEAD;
            end
          endcase
        end else if (b == CH_BSLASH) begin
          mode_d = M_ESC;
        end else begin
          run_valid_o = 1'b1;
          run_o       = single(b, KIND_BYTE, ERR_NONE);
        end
      end
      M_CONT: begin
        if (ended) begin
          fail = 1'b1; fail_code = ERR_UTF8_CUT;
        end else if (b < lo_lim || b > hi_lim) begin
          fail = 1'b1; fail_code = ERR_BAD_CONT;
        end else begin
          range_d     = 2'd0;
          left_d      = left_q - 2'd1;
          if (left_q == 2'd1) mode_d = M_BODY;
          run_valid_o = 1'b1;
          run_o       = single(b, KIND_BYTE, ERR_NONE);
        end
      end
      M_ESC: begin
        if (ended) begin
          fail = 1'b1; fail_code = ERR_ESC_CUT;
        end else begin
          mode_d      = M_BODY;
          run_valid_o = 1'b1;
          unique case (b)
            8'h22:   run_o = single(8'h22, KIND_BYTE, ERR_NONE);
            8'h5C:   run_o = single(8'h5C, KIND_BYTE, ERR_NONE);
            8'h2F:   run_o = single(8'h2F, KIND_BYTE, ERR_NONE);
            8'h62:   run_o = single(8'h08, KIND_BYTE, ERR_NONE);
            8'h66:   run_o = single(8'h0C, KIND_BYTE, ERR_NONE);
            8'h6E:   run_o = single(8'h0A, KIND_BYTE, ERR_NONE);
            8'h72:   run_o = single(8'h0D, KIND_BYTE, ERR_NONE);
            8'h74:   run_o = single(8'h09, KIND_BYTE, ERR_NONE);
            CH_U: begin
              run_valid_o = 1'b0;
              mode_d      = M_HEX;
              acc_d       = '0;
              dcnt_d      = '0;
            end
            default: begin
              run_valid_o = 1'b0;
              fail = 1'b1; fail_code = ERR_BAD_ESC;
            end
          endcase
        end
      end
      M_HEX, M_LOWHEX: begin
        if (ended) begin
          fail = 1'b1; fail_code = ERR_HEX_CUT;
        end else if (digit[4]) begin
          fail = 1'b1; fail_code = ERR_BAD_HEX;
        end else if (dcnt_q != 2'd3) begin
          acc_d  = acc_next;
          dcnt_d = dcnt_q + 2'd1;
        end else begin
          acc_d  = '0;
          dcnt_d = '0;
          if (mode_q == M_LOWHEX) begin
            if (acc_next < 16'hDC00 || acc_next > 16'hDFFF) begin
              fail = 1'b1; fail_code = ERR_BAD_LOW;
            end else begin
              hi_d        = '0;
              mode_d      = M_BODY;
              run_valid_o = 1'b1;
              run_o       = enc(cp_sup);
            end
          end else if (acc_next >= 16'hD800 && acc_next <= 16'hDBFF) begin
            hi_d   = acc_next[9:0];
            mode_d = M_SUR_BS;
          end else if (acc_next >= 16'hDC00 && acc_next <= 16'hDFFF) begin
            fail = 1'b1; fail_code = ERR_LONE_LOW;
          end else begin
            mode_d      = M_BODY;
            run_valid_o = 1'b1;
            run_o       = enc({5'd0, acc_next});
          end
        end
      end
      M_SUR_BS: begin
        if (ended || b != CH_BSLASH) begin
          fail = 1'b1; fail_code = ERR_LONE_HIGH;
        end else begin
          mode_d = M_SUR_U;
        end
      end
      M_SUR_U: begin
        if (ended || b != CH_U) begin
          fail = 1'b1; fail_code = ERR_LONE_HIGH;
        end else begin
          mode_d = M_LOWHEX;
          acc_d  = '0;
          dcnt_d = '0;
        end
      end
      default: begin
        if (ended || b != CH_QUOTE) begin
          fail = 1'b1; fail_code = ERR_NO_QUOTE;
        end else begin
          mode_d = M_BODY;
        end
      end
    endcase

    // An error drops back to idle; the saved high surrogate is kept.
    if (fail) begin
      mode_d      = M_IDLE;
      acc_d       = '0;
      dcnt_d      = '0;
      left_d      = '0;
      range_d     = '0;
      run_valid_o = 1'b1;
      run_o       = single(8'h00, KIND_ERR, fail_code);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      acc_q   <= '0;
      dcnt_q  <= '0;
      hi_q    <= '0;
      left_q  <= '0;
      range_q <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      dcnt_q  <= dcnt_d;
      hi_q    <= hi_d;
      left_q  <= left_d;
      range_q <= range_d;
    end
  end

endmodule

@@ rtl/core/jsd_run_fifo.sv @@
module jsd_run_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jsd_pkg::jsd_run_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output jsd_pkg::jsd_run_t data_o
);
  import jsd_pkg::*;

  jsd_run_t             mem_q [RUN_FIFO_DEPTH];
  logic [RUN_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RUN_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  function automatic logic [RUN_PTR_W-1:0] inc(logic [RUN_PTR_W-1:0] p);
    return (p == RUN_PTR_W'(RUN_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == RUN_CNT_W'(RUN_FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= inc(wr_ptr_q);
      if (do_pop) rd_ptr_q <= inc(rd_ptr_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ rtl/core/jsd_back.sv @@
module jsd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  jsd_pkg::jsd_run_t head_i,
  output logic              head_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output jsd_pkg::jsd_out_t out_o
);
  import jsd_pkg::*;

  logic       out_v_q;
  jsd_out_t   out_q;
  logic [1:0] idx_q;
  logic       load;
  logic       at_last;

  assign load       = head_valid_i && (!out_v_q || pop_i);
  assign at_last    = (idx_q == head_i.cnt);
  assign head_pop_o = load && at_last;
  assign empty_o    = !out_v_q;
  assign out_o      = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte    <= (head_i.kind == KIND_BYTE) ? head_i.bytes[idx_q] : 8'h00;
      out_q.result_kind <= head_i.kind;
      out_q.error_code  <= head_i.err;
      out_q.last_of_run <= at_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) out_v_q <= 1'b1;
      else if (pop_i) out_v_q <= 1'b0;
      if (load) idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  // A run is walked from its first result; the index never passes its count.
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= head_i.cnt)
    else $error("result index beyond run length");

  a_idx_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> head_valid_i)
    else $error("run left while partly sent");

  a_single_non_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.result_kind != KIND_BYTE |-> out_q.last_of_run)
    else $error("end or error result not last of its run");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_v_q)
    else $error("loaded result not shown");

endmodule

@@ rtl/core/json_string_literal_decoder.sv @@
// Path: the run of an accepted source byte is written into the run queue, then loaded result by
//   result from the queue head into the output register that drives out_data_o.
// Throughput: one source byte per cycle while the run queue is not full and each byte gives at most
//   one result; a byte that gives more results holds the output serializer while its run is walked,
//   and a 4-entry run queue absorbs it. Reset: rst_ni is asynchronous and active low; it returns the
//   decoder to idle (awaiting an opening quote) and empties both queues. There is no clearing pass.
module json_string_literal_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  jsd_pkg::jsd_in_t  in_data_i,
  output logic              empty,
  input  logic              pop,
  output jsd_pkg::jsd_out_t out_data_o
);
  import jsd_pkg::*;

  // The front decodes one source byte per transaction into a run of zero to four results.
  // A run with no result (an opening quote, a backslash, a hex digit) is not queued.
  logic     fire;
  logic     run_valid;
  jsd_run_t run;

  // Between the two halves sits a short run queue; the front stalls only when it is full.
  logic     fifo_full;
  logic     head_valid;
  jsd_run_t head;
  logic     head_pop;

  assign fire = push && !fifo_full;
  assign full = fifo_full;

  jsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .in_i        (in_data_i),
    .run_valid_o (run_valid),
    .run_o       (run)
  );

  jsd_run_fifo u_run_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire && run_valid),
    .data_i  (run),
    .full_o  (fifo_full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  // The back walks the head run one result per cycle, whenever the output register is empty or
  // popped, into that register, so a finished result can wait on pop while the front keeps
  // accepting bytes. The last result of each run carries last_of_run.
  jsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_o        (out_data_o)
  );

endmodule
